/* sv/turkish_utf8_lowercase_stream_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Turkish UTF-8 lowercase stream
// Concurrent check macros; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TURKISH_UTF8_LOWERCASE_STREAM_ASSERT_SVH
`define TURKISH_UTF8_LOWERCASE_STREAM_ASSERT_SVH
`ifndef SYNTHESIS
`define TULC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tulc: same-cycle check failed");
`define TULC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tulc: next-cycle check failed");
`else
`define TULC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TULC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/tulc_pkg.sv */
// ----------------------------------------------------------------------------
// tulc_pkg
// Shared types and byte constants of the Turkish UTF-8 lowercase stream.
// ----------------------------------------------------------------------------
package tulc_pkg;

  localparam int CAP_W     = 13;
  localparam int MAX_RES   = 4;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_PTR_W = $clog2(JOB_DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  localparam logic [1:0] LEN_PAIR   = 2'd2;
  localparam logic [1:0] LEN_TRIPLE = 2'd3;

  localparam logic [7:0] BYTE_NUL    = 8'h00;
  localparam logic [7:0] ASCII_UP_A  = 8'h41;
  localparam logic [7:0] ASCII_UP_I  = 8'h49;
  localparam logic [7:0] ASCII_UP_Z  = 8'h5A;
  localparam logic [7:0] ASCII_LO_I  = 8'h69;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] BYTE_C3     = 8'hC3;
  localparam logic [7:0] BYTE_C4     = 8'hC4;
  localparam logic [7:0] BYTE_C5     = 8'hC5;
  localparam logic [7:0] BYTE_87     = 8'h87;
  localparam logic [7:0] BYTE_96     = 8'h96;
  localparam logic [7:0] BYTE_9C     = 8'h9C;
  localparam logic [7:0] BYTE_9E     = 8'h9E;
  localparam logic [7:0] BYTE_9F     = 8'h9F;
  localparam logic [7:0] BYTE_A7     = 8'hA7;
  localparam logic [7:0] BYTE_B0     = 8'hB0;
  localparam logic [7:0] BYTE_B1     = 8'hB1;
  localparam logic [7:0] BYTE_B6     = 8'hB6;
  localparam logic [7:0] BYTE_BC     = 8'hBC;

  // One decoded input byte: up to four output bytes and an optional terminator.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    term;
  } tulc_job_t;

  typedef struct packed {
    logic       stopped;
    logic       budget_zero;
    logic [1:0] held_count;
    logic [1:0] expected_len;
  } tulc_front_stat_t;

endpackage

/* sv/tulc_front.sv */
// ----------------------------------------------------------------------------
// tulc_front
// Accepts input bytes, tracks UTF-8 sequences and the output budget, and
// turns each byte with output or a terminator into a job for the back end.
// ----------------------------------------------------------------------------
module tulc_front #(
  parameter int MAX_OUTPUT_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [7:0]                 in_byte,
  output logic                       in_stall,
  input  logic                       cfg_valid,
  input  logic [tulc_pkg::CAP_W-1:0] cfg_data,
  input  logic                       q_full,
  output logic                       push,
  output tulc_pkg::tulc_job_t        job,
  output tulc_pkg::tulc_front_stat_t stat
);
  import tulc_pkg::*;

  localparam int BW = $clog2(MAX_OUTPUT_BYTES);
  localparam int BX = BW + 2;
  localparam int CW = (BW + 1 > CAP_W) ? BW + 1 : CAP_W;

  typedef struct packed {
    logic [MAX_RES-1:0][7:0] b;
    logic [2:0]              n;
    logic [BW-1:0]           bud;
    logic                    stop;
    logic [1:0]              hcnt;
    logic [1:0]              elen;
    logic                    set_h0;
    logic                    set_h1;
  } work_t;

  logic [CAP_W-1:0] cap_r;
  logic [BW-1:0]    budget_r;
  logic             stopped_r;
  logic [1:0]       hcnt_r;
  logic [1:0]       elen_r;
  logic [7:0]       held0_r;
  logic [7:0]       held1_r;

  work_t         w;
  logic          term;
  logic          accept;
  logic          is_cont;
  logic [BW-1:0] load_cur;
  logic [BW-1:0] load_cfg;

  function automatic logic [BW-1:0] load_f(input logic [CAP_W-1:0] c);
    logic [CW-1:0] ce;
    ce = CW'(c);
    if (ce > CW'(MAX_OUTPUT_BYTES)) ce = CW'(MAX_OUTPUT_BYTES);
    if (ce == '0) return '0;
    return BW'(ce - CW'(1));
  endfunction

  function automatic work_t emit_f(input work_t s, input logic [7:0] v);
    work_t r;
    r = s;
    if (s.stop || s.bud == '0) begin
      r.stop = 1'b1;
    end else begin
      r.b[s.n[1:0]] = v;
      r.n = s.n + 3'd1;
      r.bud = s.bud - BW'(1);
      if (r.bud == '0) r.stop = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t flush_f(input work_t s, input logic [7:0] h0,
                                    input logic [7:0] h1);
    work_t r;
    r = s;
    r.hcnt = 2'd0;
    r.elen = 2'd0;
    if (s.hcnt >= 2'd1) r = emit_f(r, h0);
    if (s.hcnt >= 2'd2) r = emit_f(r, h1);
    return r;
  endfunction

  function automatic work_t fresh_f(input work_t s, input logic [7:0] v);
    work_t      r;
    logic [1:0] need;
    r = s;
    need = (v[7:5] == 3'b110) ? LEN_PAIR : LEN_TRIPLE;
    if (!s.stop) begin
      if (!v[7]) begin
        if (v == ASCII_UP_I) begin
          if ({2'b00, s.bud} >= BX'(LEN_PAIR)) begin
            r = emit_f(r, BYTE_C4);
            r = emit_f(r, BYTE_B1);
          end else begin
            r.stop = 1'b1;
          end
        end else if (v >= ASCII_UP_A && v <= ASCII_UP_Z) begin
          r = emit_f(r, v + CASE_OFFSET);
        end else begin
          r = emit_f(r, v);
        end
      end else if (v[7:5] == 3'b110 || v[7:4] == 4'b1110) begin
        if ({2'b00, s.bud} >= BX'(need)) begin
          r.set_h0 = 1'b1;
          r.hcnt = 2'd1;
          r.elen = need;
        end else begin
          r = emit_f(r, v);
        end
      end else begin
        r = emit_f(r, v);
      end
    end
    return r;
  endfunction

  assign load_cur = load_f(cap_r);
  assign load_cfg = load_f(cfg_data);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    w = '0;
    w.bud = budget_r;
    w.stop = stopped_r;
    w.hcnt = hcnt_r;
    w.elen = elen_r;
    term = 1'b0;
    if (in_byte == BYTE_NUL) begin
      if (!stopped_r) w = flush_f(w, held0_r, held1_r);
      term = 1'b1;
    end else if (stopped_r) begin
      w.hcnt = 2'd0;
      w.elen = 2'd0;
    end else if (hcnt_r == 2'd0) begin
      w = fresh_f(w, in_byte);
    end else if (elen_r == LEN_PAIR) begin
      if (is_cont) begin
        w.hcnt = 2'd0;
        w.elen = 2'd0;
        if (held0_r == BYTE_C3 && in_byte == BYTE_87) begin
          w = emit_f(w, BYTE_C3);
          w = emit_f(w, BYTE_A7);
        end else if (held0_r == BYTE_C4 && in_byte == BYTE_9E) begin
          w = emit_f(w, BYTE_C4);
          w = emit_f(w, BYTE_9F);
        end else if (held0_r == BYTE_C4 && in_byte == BYTE_B0) begin
          w = emit_f(w, ASCII_LO_I);
        end else if (held0_r == BYTE_C3 && in_byte == BYTE_96) begin
          w = emit_f(w, BYTE_C3);
          w = emit_f(w, BYTE_B6);
        end else if (held0_r == BYTE_C5 && in_byte == BYTE_9E) begin
          w = emit_f(w, BYTE_C5);
          w = emit_f(w, BYTE_9F);
        end else if (held0_r == BYTE_C3 && in_byte == BYTE_9C) begin
          w = emit_f(w, BYTE_C3);
          w = emit_f(w, BYTE_BC);
        end else begin
          w = emit_f(w, held0_r);
          w = emit_f(w, in_byte);
        end
      end else begin
        w = flush_f(w, held0_r, held1_r);
        w = fresh_f(w, in_byte);
      end
    end else if (hcnt_r == 2'd1) begin
      if (is_cont) begin
        w.set_h1 = 1'b1;
        w.hcnt = 2'd2;
      end else begin
        w = flush_f(w, held0_r, held1_r);
        w = fresh_f(w, in_byte);
      end
    end else begin
      if (is_cont) begin
        w.hcnt = 2'd0;
        w.elen = 2'd0;
        w = emit_f(w, held0_r);
        w = emit_f(w, held1_r);
        w = emit_f(w, in_byte);
      end else begin
        w = flush_f(w, held0_r, held1_r);
        w = fresh_f(w, in_byte);
      end
    end
  end

  assign job.bytes = w.b;
  assign job.count = w.n;
  assign job.term  = term;
  assign push      = accept && (term || w.n != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      budget_r  <= load_f(CAP_RESET);
      stopped_r <= (load_f(CAP_RESET) == '0);
      hcnt_r    <= 2'd0;
      elen_r    <= 2'd0;
    end else if (cfg_valid) begin
      cap_r     <= cfg_data;
      budget_r  <= load_cfg;
      stopped_r <= (load_cfg == '0);
      hcnt_r    <= 2'd0;
      elen_r    <= 2'd0;
    end else if (accept) begin
      if (term) begin
        budget_r  <= load_cur;
        stopped_r <= (load_cur == '0);
        hcnt_r    <= 2'd0;
        elen_r    <= 2'd0;
      end else begin
        budget_r  <= w.bud;
        stopped_r <= w.stop;
        hcnt_r    <= w.hcnt;
        elen_r    <= w.elen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !cfg_valid) begin
      if (w.set_h0) held0_r <= in_byte;
      if (w.set_h1) held1_r <= in_byte;
    end
  end

  assign stat.stopped      = stopped_r;
  assign stat.budget_zero  = (budget_r == '0);
  assign stat.held_count   = hcnt_r;
  assign stat.expected_len = elen_r;

endmodule

/* sv/tulc_queue.sv */
// ----------------------------------------------------------------------------
// tulc_queue
// Small job queue between the front end and the output back end.
// ----------------------------------------------------------------------------
module tulc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tulc_pkg::tulc_job_t push_job,
  input  logic                pop,
  output tulc_pkg::tulc_job_t head,
  output logic                empty,
  output logic                full
);
  import tulc_pkg::*;

  tulc_job_t            mem_r [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r;
  logic [JOB_PTR_W-1:0] rd_ptr_r;
  logic [JOB_PTR_W:0]   count_r;
  logic                 do_push;
  logic                 do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (JOB_PTR_W + 1)'(JOB_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

/* sv/tulc_back.sv */
// ----------------------------------------------------------------------------
// tulc_back
// Serializes queued jobs into single output byte transfers, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module tulc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tulc_pkg::tulc_job_t head,
  input  logic                q_empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_is_end
);
  import tulc_pkg::*;

  logic [1:0] pos_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_is_end_r;
  logic       load;
  logic       take;
  logic [2:0] total;
  logic       last;
  logic       is_data;

  assign load    = !out_valid_r || !out_stall;
  assign take    = load && !q_empty;
  assign total   = head.count + {2'b00, head.term};
  assign last    = ({1'b0, pos_r} + 3'd1) == total;
  assign is_data = {1'b0, pos_r} < head.count;
  assign pop     = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (take) pos_r <= last ? 2'd0 : pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r   <= is_data ? head.bytes[pos_r] : BYTE_NUL;
      out_is_end_r <= !is_data;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_is_end = out_is_end_r;

endmodule

/* sv/turkish_utf8_lowercase_stream.sv */
// ----------------------------------------------------------------------------
// turkish_utf8_lowercase_stream
// Turkish lowercase folding of a zero-terminated UTF-8 byte stream.
// ----------------------------------------------------------------------------
// Usage: bytes of a string enter on in_byte with in_valid; a transfer happens
// on a clock edge where in_valid is high and in_stall is low. A zero byte ends
// the string. Results leave on out_byte / out_is_end under out_valid and
// out_stall; the last transfer of each string carries out_is_end = 1 and a
// zero byte. The cfg channel writes the output capacity (cfg_valid and
// cfg_ready, always ready); it also starts a fresh string and must only be
// used while the block is idle.
// Path: an input transfer that yields results writes a job into the queue,
// and the back end then registers its results into the output register that
// drives out_valid. Each input byte yields zero to four results and the output
// port moves one result per cycle while out_stall is low; the front accepts
// one byte per cycle while the four-entry job queue has room, and in_stall
// rises only when that queue is full.
// Reset (synchronous, rst_n low) loads a capacity of 256, clears the pending
// sequence and the queue, and drops any result in the output register.
// A stalled output holds its byte; the queue absorbs the front meanwhile.
// ----------------------------------------------------------------------------
`include "turkish_utf8_lowercase_stream_assert.svh"

module turkish_utf8_lowercase_stream #(
  parameter int MAX_OUTPUT_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [7:0]                 in_byte,
  output logic                       in_stall,
  output logic                       out_valid,
  output logic [7:0]                 out_byte,
  output logic                       out_is_end,
  input  logic                       out_stall,
  input  logic                       cfg_valid,
  input  logic [tulc_pkg::CAP_W-1:0] cfg_data,
  output logic                       cfg_ready
);
  import tulc_pkg::*;

  // Front-to-back job handoff.
  tulc_job_t        push_job;
  tulc_job_t        head_job;
  tulc_front_stat_t stat;
  logic             push;
  logic             pop;
  logic             q_empty;
  logic             q_full;

  // Configuration writes must only be issued while idle (not enforced); cfg_ready is always high.
  assign cfg_ready = 1'b1;

  // The front end owns all string state and the output budget; it turns
  // each accepted byte that yields output combinationally into a complete job.
  tulc_front #(
    .MAX_OUTPUT_BYTES(MAX_OUTPUT_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job),
    .stat     (stat)
  );

  // The queue lets the front keep accepting while the output drains.
  tulc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head_job),
    .empty   (q_empty),
    .full    (q_full)
  );

  // The back end walks each job one byte per cycle into the output register while out_stall is low.
  tulc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_is_end(out_is_end)
  );

  // While output is running the budget is never empty.
  `TULC_ASSERT_IMP(a_budget_live, clk, rst_n, !stat.stopped, !stat.budget_zero)
  // A held continuation only exists inside a three-byte sequence.
  `TULC_ASSERT_IMP(a_two_held, clk, rst_n, stat.held_count == 2'd2, stat.expected_len == LEN_TRIPLE)
  // A capacity write drops any pending sequence.
  `TULC_ASSERT_NXT(a_cfg_clears, clk, rst_n, cfg_valid && cfg_ready, stat.held_count == 2'd0)
  // The terminator transfer always carries a zero byte.
  `TULC_ASSERT_IMP(a_term_zero, clk, rst_n, out_valid && out_is_end, out_byte == BYTE_NUL)

endmodule
